@@ hdl/tii_pkg.sv @@
// Shared constants and types for the table interpolation core.
// No dependencies; imported by table_interpolate_int_core.
`default_nettype none

package tii_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int SIZE_W      = 7;
    localparam int INDEX_W     = 6;
    localparam int WORD_W      = 32;
    localparam int PROD_W      = 2 * WORD_W;

    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_USER_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

    // request kinds carried on tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // quotient magnitudes above this clip
    localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(64'h4_0000_0000);

    typedef struct packed {
        logic signed [WORD_W-1:0] query_value;
        logic signed [WORD_W-1:0] entry_value;
        logic signed [WORD_W-1:0] entry_key;
        logic [INDEX_W-1:0]       entry_index;
    } t_in_fields;

endpackage

`default_nettype wire

@@ hdl/table_interpolate_int_core.sv @@
// Piecewise linear interpolation lookup table, top level.
// Depends on tii_pkg (constants, request kinds, input field layout).
// Holds key/value tables, a binary-search sequencer and a serial divider.
//
// A load request writes one key/value pair. A query binary-searches the first table_size
// entries (each probe passes a search state and a probe state on the registered table read,
// at most six probes for 64 entries), reads the bracketing pair, forms the 32x32 product,
// then runs a restoring divider that retires one quotient bit per cycle (64 quotient bits),
// and finishes with a saturate state and an output state. An exact hit at a probe goes
// straight to the output state. The input is not ready while a query is in work; a finished
// result waits in the output register, so the next request is taken while the result is
// still pending. Table entries must be loaded before a query reads them.
`default_nettype none

module table_interpolate_int_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration: table_size
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tii_pkg::SIZE_W-1:0]     i_cfg_data,
    // request stream
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: entry_index[5:0], entry_key[37:6], entry_value[69:38], query_value[101:70]
    input  wire logic [tii_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: func[0]
    input  wire logic [0:0]                     i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata: result[31:0]
    output logic [tii_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // tuser: saturated[0], bad_segment[1]
    output logic [tii_pkg::OUT_USER_W-1:0]      o_m_axis_tuser
);

    import tii_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PROBE,
        ST_RD_L,
        ST_RD_R,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } t_state;

    t_state                    r_state;
    logic [SIZE_W-1:0]         r_table_size;

    logic [WORD_W-1:0]         r_key_mem [TABLE_DEPTH];
    logic [WORD_W-1:0]         r_val_mem [TABLE_DEPTH];
    logic signed [WORD_W-1:0]  r_rd_key;
    logic signed [WORD_W-1:0]  r_rd_val;

    logic signed [WORD_W-1:0]  r_query;
    logic [ADDR_W-1:0]         r_lo;
    logic [ADDR_W-1:0]         r_hi;
    logic [ADDR_W-1:0]         r_mid;
    logic signed [WORD_W-1:0]  r_kl;
    logic signed [WORD_W-1:0]  r_vl;
    logic                      r_neg;
    logic [WORD_W-1:0]         r_mdx;
    logic [WORD_W-1:0]         r_mdy;
    logic [WORD_W-1:0]         r_den;
    logic [PROD_W-1:0]         r_prod;
    logic [WORD_W-1:0]         r_rem;
    logic [5:0]                r_cnt;

    logic signed [WORD_W-1:0]  r_res;
    logic                      r_sat;
    logic                      r_bad;

    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic [OUT_USER_W-1:0]     r_out_user;

    t_in_fields                w_in;
    logic                      w_accept;
    logic                      w_we;
    logic [ADDR_W-1:0]         w_rd_addr;
    logic [ADDR_W-1:0]         w_hi_init;
    logic [ADDR_W:0]           w_sum;
    logic [ADDR_W-1:0]         w_mid;
    logic                      w_more;
    logic                      w_out_free;

    logic signed [WORD_W:0]    w_den;
    logic signed [WORD_W:0]    w_dx;
    logic signed [WORD_W:0]    w_dy;
    logic [WORD_W:0]           w_mden;
    logic [WORD_W:0]           w_mdx;
    logic [WORD_W:0]           w_mdy;

    logic [WORD_W:0]           w_trial;
    logic                      w_qbit;
    logic [WORD_W:0]           w_rem_sub;

    logic signed [WORD_W+3:0]  w_qt;
    logic signed [WORD_W+4:0]  w_sum_res;

    assign w_in     = t_in_fields'(i_s_axis_tdata[$bits(t_in_fields)-1:0]);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_we     = w_accept && (i_s_axis_tuser[0] == FUNC_LOAD)
                      && (int'(w_in.entry_index) < TABLE_DEPTH);

    // clamp table_size to 2..TABLE_DEPTH, upper search bound is size - 1
    always_comb begin
        if (r_table_size < SIZE_MIN) begin
            w_hi_init = ADDR_W'(1);
        end else if (int'(r_table_size) > TABLE_DEPTH) begin
            w_hi_init = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            w_hi_init = ADDR_W'(r_table_size - SIZE_W'(1));
        end
    end

    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid  = w_sum[ADDR_W:1];
    assign w_more = (r_hi - r_lo) > ADDR_W'(1);

    always_comb begin
        unique case (r_state)
            ST_SEARCH: w_rd_addr = w_more ? w_mid : r_lo;
            ST_RD_L:   w_rd_addr = r_hi;
            default:   w_rd_addr = r_lo;
        endcase
    end

    // table memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_key_mem[w_in.entry_index[ADDR_W-1:0]] <= w_in.entry_key;
            r_val_mem[w_in.entry_index[ADDR_W-1:0]] <= w_in.entry_value;
        end
        r_rd_key <= r_key_mem[w_rd_addr];
        r_rd_val <= r_val_mem[w_rd_addr];
    end

    // segment differences, hi entry on the read port, lo entry latched
    assign w_den  = {r_rd_key[WORD_W-1], r_rd_key} - {r_kl[WORD_W-1], r_kl};
    assign w_dx   = {r_query[WORD_W-1], r_query} - {r_kl[WORD_W-1], r_kl};
    assign w_dy   = {r_rd_val[WORD_W-1], r_rd_val} - {r_vl[WORD_W-1], r_vl};
    assign w_mden = w_den[WORD_W] ? -w_den : w_den;
    assign w_mdx  = w_dx[WORD_W] ? -w_dx : w_dx;
    assign w_mdy  = w_dy[WORD_W] ? -w_dy : w_dy;

    // restoring divider step
    assign w_trial   = {r_rem, r_prod[PROD_W-1]};
    assign w_qbit    = w_trial >= {1'b0, r_den};
    assign w_rem_sub = w_trial - {1'b0, r_den};

    assign w_qt      = r_neg ? -$signed({1'b0, r_prod[WORD_W+2:0]})
                             : $signed({1'b0, r_prod[WORD_W+2:0]});
    assign w_sum_res = {w_qt[WORD_W+3], w_qt} + (WORD_W+5)'(r_vl);

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_table_size <= SIZE_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_table_size <= i_cfg_data;
            end
            if (r_out_valid && i_m_axis_tready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_s_axis_tuser[0] == FUNC_QUERY)) begin
                        r_query <= w_in.query_value;
                        r_lo    <= '0;
                        r_hi    <= w_hi_init;
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (w_more) begin
                        r_mid   <= w_mid;
                        r_state <= ST_PROBE;
                    end else begin
                        r_state <= ST_RD_L;
                    end
                end
                ST_PROBE: begin
                    if (r_rd_key < r_query) begin
                        r_lo    <= r_mid;
                        r_state <= ST_SEARCH;
                    end else if (r_rd_key > r_query) begin
                        r_hi    <= r_mid;
                        r_state <= ST_SEARCH;
                    end else begin
                        r_res   <= r_rd_val;
                        r_sat   <= 1'b0;
                        r_bad   <= 1'b0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_RD_L: begin
                    r_kl    <= r_rd_key;
                    r_vl    <= r_rd_val;
                    r_state <= ST_RD_R;
                end
                ST_RD_R: begin
                    if (w_den == '0) begin
                        r_res   <= '0;
                        r_sat   <= 1'b0;
                        r_bad   <= 1'b1;
                        r_state <= ST_EMIT;
                    end else begin
                        r_neg   <= (w_dx[WORD_W] != w_dy[WORD_W]) != w_den[WORD_W];
                        r_mdx   <= w_mdx[WORD_W-1:0];
                        r_mdy   <= w_mdy[WORD_W-1:0];
                        r_den   <= w_mden[WORD_W-1:0];
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= PROD_W'(r_mdx) * PROD_W'(r_mdy);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_prod <= {r_prod[PROD_W-2:0], w_qbit};
                    r_rem  <= w_qbit ? w_rem_sub[WORD_W-1:0] : w_trial[WORD_W-1:0];
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_bad <= 1'b0;
                    if (r_prod > MAG_LIMIT) begin
                        r_res <= r_neg ? {1'b1, {(WORD_W-1){1'b0}}}
                                       : {1'b0, {(WORD_W-1){1'b1}}};
                        r_sat <= 1'b1;
                    end else if (w_sum_res > (WORD_W+5)'(32'sh7FFF_FFFF)) begin
                        r_res <= {1'b0, {(WORD_W-1){1'b1}}};
                        r_sat <= 1'b1;
                    end else if (w_sum_res < -(WORD_W+5)'(33'sh0_8000_0000)) begin
                        r_res <= {1'b1, {(WORD_W-1){1'b0}}};
                        r_sat <= 1'b1;
                    end else begin
                        r_res <= w_sum_res[WORD_W-1:0];
                        r_sat <= 1'b0;
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_out_user  <= {r_bad, r_sat};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTH
    a_bad_seg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> (o_m_axis_tdata == '0 && !o_m_axis_tuser[0]))
        else $error("bad segment result not zero or flagged saturated");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH || r_state == ST_PROBE) |-> (r_lo < r_hi))
        else $error("search bounds crossed");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser[0] == FUNC_QUERY) |=> !o_s_axis_tready)
        else $error("ready while query in work");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
